### rtl/erfinv_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Inverse error function package
// Widths, polynomial coefficients and the sideband type that travels with
// every request through the pipeline.
// ----------------------------------------------------------------------------
package erfinv_pkg;

   // Argument and result formats.
   localparam int IN_FRAC_BITS  = 23;
   localparam int OUT_FRAC_BITS = 20;
   localparam int ARG_W         = 24;
   localparam int RES_W         = 24;
   localparam int MAG_W         = IN_FRAC_BITS + 1;

   // Logarithm section.
   localparam int TWO_F      = 2 * IN_FRAC_BITS;
   localparam int Q_W        = TWO_F + 1;
   localparam int E_W        = $clog2(Q_W);
   localparam int Y_FRAC     = 30;
   localparam int Y_W        = Y_FRAC + 1;
   localparam int LOG_ROUNDS = 28;
   localparam int LQ_W       = E_W + LOG_ROUNDS;
   localparam int LQ_LO_W    = LQ_W / 2;
   localparam int LQ_HI_W    = LQ_W - LQ_LO_W;
   localparam int LN2_W      = 28;
   localparam logic [LN2_W-1:0] LN2_Q28 = 28'd186065279;
   localparam int LN_SHIFT   = 32;
   localparam int W_FRAC     = 24;
   localparam int W_W        = LQ_W + LN2_W - LN_SHIFT;

   // Square root section.
   localparam int SQ_N_W   = W_W + W_FRAC;
   localparam int SQ_ROUNDS = (SQ_N_W + 1) / 2;
   localparam int SQ_W     = SQ_N_W + 1;

   // Polynomial section.
   localparam int D_W     = 28;
   localparam int UD_W    = D_W - 1;
   localparam int P_W     = 40;
   localparam int UP_W    = P_W - 1;
   localparam int UP_LO_W = 20;
   localparam int UP_HI_W = UP_W - UP_LO_W;
   localparam int TERMS   = 9;

   // Output scaling.
   localparam int PM_W      = P_W - 2;
   localparam int PM_LO_W   = PM_W / 2;
   localparam int PM_HI_W   = PM_W - PM_LO_W;
   localparam int PROD_W    = PM_W + MAG_W;
   localparam int OUT_SHIFT = 30 + IN_FRAC_BITS - OUT_FRAC_BITS;
   localparam int OMAG_W    = PROD_W + 1 - OUT_SHIFT;

   typedef logic signed [P_W-1:0] coef_type;

   // Coefficients in Q.32, highest order first.
   localparam coef_type COEF_LOW [TERMS] = '{
      40'sd121, 40'sd1474, -40'sd15133, -40'sd18861, 40'sd938798,
      -40'sd5384708, -40'sd17943006, 40'sd1059313856, 40'sd6448504314
   };
   localparam coef_type COEF_HIGH [TERMS] = '{
      -40'sd859914, 40'sd433579, 40'sd5795385, -40'sd15777255, 40'sd24650998,
      -40'sd32738222, 40'sd40539640, 40'sd4302157329, 40'sd12167542792
   };

   // Control and operand data that ride along with each request.
   typedef struct packed {
      logic             valid;
      logic             neg;
      logic             full;
      logic [MAG_W-1:0] mag;
   } side_type;

endpackage
`default_nettype wire

### rtl/inverse_error_function.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Inverse error function
// Throughput: one request per cycle; the pipeline moves as a whole and
// stalls only while a result waits in the output register.
// Reset clears every valid bit; datapath registers are not reset.
// ----------------------------------------------------------------------------
// Computes erfinv(x) for x in Q1.23, giving Q4.20. The pipeline forms
// w = -ln(1 - x*x) with a squaring log2 unit (one bit per stage), takes a
// digit-by-digit square root (one digit per stage) for the tail branch,
// evaluates a nine-term polynomial with two stages per Horner step and
// scales the result by |x|. Full-scale arguments and results beyond the
// output range are clamped and flagged.
// ----------------------------------------------------------------------------
module inverse_error_function (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_ready,
   input  wire logic signed [erfinv_pkg::ARG_W-1:0]  req_arg_value,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_ready,
   output logic signed [erfinv_pkg::RES_W-1:0]       rsp_inv_erf_value,
   output logic                                      rsp_saturated
);

   localparam int ARG_W     = erfinv_pkg::ARG_W;
   localparam int RES_W     = erfinv_pkg::RES_W;
   localparam int MAG_W     = erfinv_pkg::MAG_W;
   localparam int W_W       = erfinv_pkg::W_W;
   localparam int W_FRAC    = erfinv_pkg::W_FRAC;
   localparam int SQ_W      = erfinv_pkg::SQ_W;
   localparam int SQR       = erfinv_pkg::SQ_ROUNDS;
   localparam int D_W       = erfinv_pkg::D_W;
   localparam int P_W       = erfinv_pkg::P_W;
   localparam int PM_W      = erfinv_pkg::PM_W;
   localparam int PM_LO_W   = erfinv_pkg::PM_LO_W;
   localparam int PM_HI_W   = erfinv_pkg::PM_HI_W;
   localparam int PROD_W    = erfinv_pkg::PROD_W;
   localparam int OUT_SHIFT = erfinv_pkg::OUT_SHIFT;
   localparam int OMAG_W    = erfinv_pkg::OMAG_W;

   // Branch threshold 5.0, low branch center 2.5, high branch center 3.0.
   localparam logic [W_W-1:0] W_FIVE     = W_W'(5) << W_FRAC;
   localparam logic [D_W-1:0] D_HALFFIVE = D_W'(5) << (W_FRAC - 1);
   localparam logic [D_W-1:0] D_THREE    = D_W'(3) << W_FRAC;
   localparam logic [OMAG_W-1:0] LIM_POS = {{(OMAG_W-RES_W+1){1'b0}}, {(RES_W-1){1'b1}}};
   localparam logic [OMAG_W-1:0] LIM_NEG = {{(OMAG_W-RES_W){1'b0}}, 1'b1, {(RES_W-1){1'b0}}};
   localparam logic [PROD_W:0]   OUT_HALF = {{(PROD_W-OUT_SHIFT+1){1'b0}}, 1'b1,
                                             {(OUT_SHIFT-1){1'b0}}};

   // The whole pipeline advances unless a result is held in the output
   // register and the consumer is not taking it.
   logic enable;
   assign enable    = !rsp_valid || rsp_ready;
   assign req_ready = enable;

   // ---------------------------------------------------------------------
   // Input stage: magnitude, sign and full-scale detect.
   // ---------------------------------------------------------------------
   erfinv_pkg::side_type s0_in;
   erfinv_pkg::side_type s0_ff;
   logic [ARG_W-1:0]     arg_neg;

   assign arg_neg     = -req_arg_value;
   assign s0_in.valid = req_valid;
   assign s0_in.neg   = req_arg_value[ARG_W-1];
   assign s0_in.mag   = req_arg_value[ARG_W-1] ? MAG_W'(arg_neg) : MAG_W'(req_arg_value);
   assign s0_in.full  = s0_in.mag[MAG_W-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_ff <= '0;
      end else if (enable) begin
         s0_ff <= s0_in;
      end
   end

   // ---------------------------------------------------------------------
   // w = -ln(1 - x*x) in Q.24.
   // ---------------------------------------------------------------------
   erfinv_pkg::side_type side_l;
   logic [W_W-1:0]       w_l;

   erfinv_log u_log (
      .clock    (clock),
      .reset    (reset),
      .enable   (enable),
      .side_in  (s0_ff),
      .side_out (side_l),
      .w_out    (w_l)
   );

   // ---------------------------------------------------------------------
   // Square root of w, one result digit per stage. The value w is carried
   // along so that the low branch can use it when the root is done.
   // ---------------------------------------------------------------------
   logic [SQ_W-1:0]      rem_ff  [SQR];
   logic [SQ_W-1:0]      res_ff  [SQR];
   logic [W_W-1:0]       wq_ff   [SQR];
   erfinv_pkg::side_type sides_ff [SQR];

   for (genvar i = 0; i < SQR; i++) begin : g_sqrt
      localparam logic [SQ_W-1:0] BIT = {{(SQ_W-1){1'b0}}, 1'b1} << (2 * (SQR - 1 - i));
      logic [SQ_W-1:0]      rem_src;
      logic [SQ_W-1:0]      res_src;
      logic [W_W-1:0]       w_src;
      erfinv_pkg::side_type side_src;
      logic [SQ_W-1:0]      trial;

      if (i == 0) begin : g_first
         assign rem_src  = {{(SQ_W-W_W-W_FRAC){1'b0}}, w_l, {W_FRAC{1'b0}}};
         assign res_src  = '0;
         assign w_src    = w_l;
         assign side_src = side_l;
      end else begin : g_next
         assign rem_src  = rem_ff[i-1];
         assign res_src  = res_ff[i-1];
         assign w_src    = wq_ff[i-1];
         assign side_src = sides_ff[i-1];
      end

      assign trial = res_src + BIT;

      always_ff @(posedge clock) begin
         if (enable) begin
            wq_ff[i] <= w_src;
            if (rem_src >= trial) begin
               rem_ff[i] <= rem_src - trial;
               res_ff[i] <= (res_src >> 1) + BIT;
            end else begin
               rem_ff[i] <= rem_src;
               res_ff[i] <= res_src >> 1;
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            sides_ff[i] <= '0;
         end else if (enable) begin
            sides_ff[i] <= side_src;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Branch select: polynomial variable d and coefficient set.
   // ---------------------------------------------------------------------
   erfinv_pkg::side_type  sided_ff;
   logic                  low_ff;
   logic signed [D_W-1:0] d_ff;
   logic                  low_in;
   logic [W_W-1:0]        w_sq;

   assign w_sq   = wq_ff[SQR-1];
   assign low_in = w_sq < W_FIVE;

   always_ff @(posedge clock) begin
      if (enable) begin
         low_ff <= low_in;
         d_ff   <= low_in ? D_W'(w_sq) - D_HALFFIVE : D_W'(res_ff[SQR-1]) - D_THREE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sided_ff <= '0;
      end else if (enable) begin
         sided_ff <= sides_ff[SQR-1];
      end
   end

   // ---------------------------------------------------------------------
   // Polynomial in Q.32.
   // ---------------------------------------------------------------------
   erfinv_pkg::side_type  side_h;
   logic signed [P_W-1:0] p_h;

   erfinv_horner u_horner (
      .clock    (clock),
      .reset    (reset),
      .enable   (enable),
      .side_in  (sided_ff),
      .low_in   (low_ff),
      .d_in     (d_ff),
      .side_out (side_h),
      .p_out    (p_h)
   );

   // ---------------------------------------------------------------------
   // Scale by |x|: clamp p at zero and round it to Q.30, multiply in two
   // halves, then round to nearest into the output format.
   // ---------------------------------------------------------------------
   erfinv_pkg::side_type     side_f0_ff;
   erfinv_pkg::side_type     side_f1_ff;
   erfinv_pkg::side_type     side_f2_ff;
   logic [PM_W-1:0]          pm_ff;
   logic [P_W-1:0]           p_plus;
   logic [PM_LO_W+MAG_W-1:0] ml_ff;
   logic [PM_HI_W+MAG_W-1:0] mh_ff;
   logic [PROD_W:0]          prod_rnd;
   logic [OMAG_W-1:0]        mag_ff;

   assign p_plus   = p_h + P_W'(2);
   assign prod_rnd = (PROD_W+1)'(ml_ff) + {1'b0, mh_ff, {PM_LO_W{1'b0}}} + OUT_HALF;

   always_ff @(posedge clock) begin
      if (enable) begin
         pm_ff  <= p_h[P_W-1] ? '0 : p_plus[PM_W+1:2];
         ml_ff  <= pm_ff[PM_LO_W-1:0] * side_f0_ff.mag;
         mh_ff  <= pm_ff[PM_W-1:PM_LO_W] * side_f0_ff.mag;
         mag_ff <= prod_rnd[PROD_W:OUT_SHIFT];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         side_f0_ff <= '0;
         side_f1_ff <= '0;
         side_f2_ff <= '0;
      end else if (enable) begin
         side_f0_ff <= side_h;
         side_f1_ff <= side_f0_ff;
         side_f2_ff <= side_f1_ff;
      end
   end

   // ---------------------------------------------------------------------
   // Output register: saturation at the range ends and sign.
   // ---------------------------------------------------------------------
   logic                    rsp_valid_ff;
   logic signed [RES_W-1:0] value_ff;
   logic                    sat_ff;
   logic [OMAG_W-1:0]       lim;
   logic [OMAG_W-1:0]       mag_sel;
   logic [OMAG_W-1:0]       mag_signed;
   logic                    sat_in;

   always_comb begin
      lim        = side_f2_ff.neg ? LIM_NEG : LIM_POS;
      sat_in     = side_f2_ff.full || (mag_ff > lim);
      mag_sel    = sat_in ? lim : mag_ff;
      mag_signed = side_f2_ff.neg ? -mag_sel : mag_sel;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (enable) begin
         rsp_valid_ff <= side_f2_ff.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         value_ff <= mag_signed[RES_W-1:0];
         sat_ff   <= sat_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_inv_erf_value = value_ff;
   assign rsp_saturated     = sat_ff;

   // ---------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------

   // A saturated result always sits at one end of the output range.
   a_sat_at_end : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_saturated) |->
         (rsp_inv_erf_value == {1'b0, {(RES_W-1){1'b1}}} ||
          rsp_inv_erf_value == {1'b1, {(RES_W-1){1'b0}}}))
      else $error("saturated result is not at a range end");

   // Reset empties the pipeline, so no result follows it directly.
   a_reset_empty : assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

   // Requests are refused only while a result is held back by the consumer.
   a_refuse_cause : assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (rsp_valid && !rsp_ready))
      else $error("request refused without a held result");

endmodule
`default_nettype wire

### rtl/erfinv_log.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Negative natural logarithm pipeline
// Forms q = 1 - x*x, normalizes it and computes w = -ln(q) in Q.24.
// ----------------------------------------------------------------------------
module erfinv_log (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        enable,
   input  wire erfinv_pkg::side_type        side_in,
   output erfinv_pkg::side_type             side_out,
   output logic [erfinv_pkg::W_W-1:0]       w_out
);

   localparam int Q_W     = erfinv_pkg::Q_W;
   localparam int E_W     = erfinv_pkg::E_W;
   localparam int Y_W     = erfinv_pkg::Y_W;
   localparam int Y_FRAC  = erfinv_pkg::Y_FRAC;
   localparam int LR      = erfinv_pkg::LOG_ROUNDS;
   localparam int LQ_W    = erfinv_pkg::LQ_W;
   localparam int LQ_LO_W = erfinv_pkg::LQ_LO_W;
   localparam int LQ_HI_W = erfinv_pkg::LQ_HI_W;
   localparam int LN2_W   = erfinv_pkg::LN2_W;
   localparam int MAG_W   = erfinv_pkg::MAG_W;
   localparam int TOT_W   = LQ_W + LN2_W;
   localparam int LAT     = LR + 7;
   localparam logic [Q_W-1:0] ONE_Q = {1'b1, {(Q_W-1){1'b0}}};
   localparam logic [E_W-1:0] TWO_F = E_W'(erfinv_pkg::TWO_F);

   erfinv_pkg::side_type side_ff [LAT];

   logic [Q_W-1:0]           sq_ff;
   logic [2*MAG_W-1:0]       sq_in;
   logic [Q_W-1:0]           q_ff;
   logic [Q_W-1:0]           q2_ff;
   logic [E_W-1:0]           e2_ff;
   logic [E_W-1:0]           e2_in;
   logic [Q_W+Y_FRAC-1:0]    norm;
   logic [Y_W-1:0]           y_ff    [LR+1];
   logic [LR-1:0]            frac_ff [LR+1];
   logic [E_W-1:0]           e_ff    [LR+1];
   logic [E_W-1:0]           int_part;
   logic [LQ_W-1:0]          lq_ff;
   logic [LQ_LO_W+LN2_W-1:0] pl_ff;
   logic [LQ_HI_W+LN2_W-1:0] ph_ff;
   logic [TOT_W-1:0]         total;
   logic [erfinv_pkg::W_W-1:0] w_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < LAT; k++) side_ff[k] <= '0;
      end else if (enable) begin
         side_ff[0] <= side_in;
         for (int k = 1; k < LAT; k++) side_ff[k] <= side_ff[k-1];
      end
   end

   assign sq_in = side_in.mag * side_in.mag;

   // Leading one of q.
   always_comb begin
      e2_in = '0;
      for (int i = 0; i < Q_W; i++) begin
         if (q_ff[i]) e2_in = E_W'(i);
      end
   end

   assign norm = {q2_ff, {Y_FRAC{1'b0}}} >> e2_ff;

   always_ff @(posedge clock) begin
      if (enable) begin
         sq_ff      <= sq_in[Q_W-1:0];
         q_ff       <= ONE_Q - sq_ff;
         q2_ff      <= q_ff;
         e2_ff      <= e2_in;
         y_ff[0]    <= norm[Y_W-1:0];
         frac_ff[0] <= '0;
         e_ff[0]    <= e2_ff;
      end
   end

   // One fraction bit of log2 per stage, by squaring the mantissa.
   for (genvar r = 0; r < LR; r++) begin : g_round
      logic [2*Y_W-1:0] sqr;
      logic [Y_W:0]     y2;
      assign sqr = y_ff[r] * y_ff[r];
      assign y2  = sqr[Y_FRAC +: Y_W+1];
      always_ff @(posedge clock) begin
         if (enable) begin
            e_ff[r+1] <= e_ff[r];
            if (y2[Y_W]) begin
               y_ff[r+1]    <= y2[Y_W:1];
               frac_ff[r+1] <= {frac_ff[r][LR-2:0], 1'b1};
            end else begin
               y_ff[r+1]    <= y2[Y_W-1:0];
               frac_ff[r+1] <= {frac_ff[r][LR-2:0], 1'b0};
            end
         end
      end
   end

   assign int_part = TWO_F - e_ff[LR];
   assign total    = TOT_W'(pl_ff) + {ph_ff, {LQ_LO_W{1'b0}}}
                     + {{(TOT_W-erfinv_pkg::LN_SHIFT){1'b0}}, 1'b1,
                        {(erfinv_pkg::LN_SHIFT-1){1'b0}}};

   always_ff @(posedge clock) begin
      if (enable) begin
         lq_ff <= {int_part, {LR{1'b0}}} - LQ_W'(frac_ff[LR]);
         pl_ff <= lq_ff[LQ_LO_W-1:0] * erfinv_pkg::LN2_Q28;
         ph_ff <= lq_ff[LQ_W-1:LQ_LO_W] * erfinv_pkg::LN2_Q28;
         w_ff  <= total[TOT_W-1:erfinv_pkg::LN_SHIFT];
      end
   end

   assign side_out = side_ff[LAT-1];
   assign w_out    = w_ff;

endmodule
`default_nettype wire

### rtl/erfinv_horner.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Horner polynomial pipeline
// Eight multiply and add steps, each split into a partial product stage and
// a sum stage. The branch flag picks the coefficient set.
// ----------------------------------------------------------------------------
module erfinv_horner (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               enable,
   input  wire erfinv_pkg::side_type               side_in,
   input  wire logic                               low_in,
   input  wire logic signed [erfinv_pkg::D_W-1:0]  d_in,
   output erfinv_pkg::side_type                    side_out,
   output logic signed [erfinv_pkg::P_W-1:0]       p_out
);

   localparam int STEPS   = erfinv_pkg::TERMS - 1;
   localparam int P_W     = erfinv_pkg::P_W;
   localparam int D_W     = erfinv_pkg::D_W;
   localparam int UP_W    = erfinv_pkg::UP_W;
   localparam int UD_W    = erfinv_pkg::UD_W;
   localparam int UP_LO_W = erfinv_pkg::UP_LO_W;
   localparam int UP_HI_W = erfinv_pkg::UP_HI_W;
   localparam int SUM_W   = UP_W + UD_W;
   localparam int SH      = erfinv_pkg::W_FRAC;

   logic signed [P_W-1:0]      p_src    [1:STEPS];
   logic signed [D_W-1:0]      d_src    [1:STEPS];
   logic                       low_src  [1:STEPS];
   erfinv_pkg::side_type       side_src [1:STEPS];

   logic [UP_LO_W+UD_W-1:0]    ppl_ff   [1:STEPS];
   logic [UP_HI_W+UD_W-1:0]    pph_ff   [1:STEPS];
   logic                       ng_ff    [1:STEPS];
   logic signed [D_W-1:0]      da_ff    [1:STEPS];
   logic                       lowa_ff  [1:STEPS];
   erfinv_pkg::side_type       sidea_ff [1:STEPS];
   logic signed [P_W-1:0]      pb_ff    [1:STEPS];
   logic signed [D_W-1:0]      db_ff    [1:STEPS];
   logic                       lowb_ff  [1:STEPS];
   erfinv_pkg::side_type       sideb_ff [1:STEPS];

   for (genvar j = 1; j <= STEPS; j++) begin : g_step
      logic [P_W-1:0]        p_abs;
      logic [D_W-1:0]        d_abs;
      logic [SUM_W-1:0]      sum;
      logic signed [P_W-1:0] r;

      if (j == 1) begin : g_first
         assign p_src[j]    = low_in ? erfinv_pkg::COEF_LOW[0] : erfinv_pkg::COEF_HIGH[0];
         assign d_src[j]    = d_in;
         assign low_src[j]  = low_in;
         assign side_src[j] = side_in;
      end else begin : g_next
         assign p_src[j]    = pb_ff[j-1];
         assign d_src[j]    = db_ff[j-1];
         assign low_src[j]  = lowb_ff[j-1];
         assign side_src[j] = sideb_ff[j-1];
      end

      assign p_abs = p_src[j][P_W-1] ? -p_src[j] : p_src[j];
      assign d_abs = d_src[j][D_W-1] ? -d_src[j] : d_src[j];

      // Magnitude product rounded half up, sign applied afterwards.
      assign sum = SUM_W'(ppl_ff[j]) + {pph_ff[j], {UP_LO_W{1'b0}}}
                   + {{(SUM_W-SH){1'b0}}, 1'b1, {(SH-1){1'b0}}};
      assign r   = sum[SH +: P_W];

      always_ff @(posedge clock) begin
         if (enable) begin
            ppl_ff[j]  <= p_abs[UP_LO_W-1:0] * d_abs[UD_W-1:0];
            pph_ff[j]  <= p_abs[UP_W-1:UP_LO_W] * d_abs[UD_W-1:0];
            ng_ff[j]   <= p_src[j][P_W-1] ^ d_src[j][D_W-1];
            da_ff[j]   <= d_src[j];
            lowa_ff[j] <= low_src[j];
            pb_ff[j]   <= (lowa_ff[j] ? erfinv_pkg::COEF_LOW[j] : erfinv_pkg::COEF_HIGH[j])
                          + (ng_ff[j] ? -r : r);
            db_ff[j]   <= da_ff[j];
            lowb_ff[j] <= lowa_ff[j];
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            sidea_ff[j] <= '0;
            sideb_ff[j] <= '0;
         end else if (enable) begin
            sidea_ff[j] <= side_src[j];
            sideb_ff[j] <= sidea_ff[j];
         end
      end
   end

   assign side_out = sideb_ff[STEPS];
   assign p_out    = pb_ff[STEPS];

endmodule
`default_nettype wire

### sim/erfinv_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Inverse error function checker
// Watches both channels, predicts each result from the accepted argument and
// compares it field by field with what the block returns, in order.
// ----------------------------------------------------------------------------
module erfinv_checker (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   input  wire logic                                req_ready,
   input  wire logic signed [erfinv_pkg::ARG_W-1:0] req_arg_value,
   input  wire logic                                rsp_valid,
   input  wire logic                                rsp_ready,
   input  wire logic signed [erfinv_pkg::RES_W-1:0] rsp_inv_erf_value,
   input  wire logic                                rsp_saturated,
   output int                                       error_count,
   output int                                       pending_count
);
   localparam int ARG_W        = erfinv_pkg::ARG_W;
   localparam int RES_W        = erfinv_pkg::RES_W;
   localparam int TWO_F        = erfinv_pkg::TWO_F;
   localparam int LOG_ROUNDS   = erfinv_pkg::LOG_ROUNDS;
   localparam int IN_FRAC_BITS = erfinv_pkg::IN_FRAC_BITS;
   localparam int OUT_SHIFT    = erfinv_pkg::OUT_SHIFT;

   typedef struct packed {
      logic [RES_W-1:0] value;
      logic             sat;
   } erfinv_result_type;

   localparam longint LOW_C [9] = '{121, 1474, -15133, -18861, 938798, -5384708,
      -17943006, 1059313856, 64'sd6448504314};
   localparam longint HIGH_C [9] = '{-859914, 433579, 5795385, -15777255, 24650998,
      -32738222, 40539640, 64'sd4302157329, 64'sd12167542792};

   erfinv_result_type expected_results[$];

   function automatic longint scaled_product(longint a, longint b);
      logic   neg_product;
      longint ua;
      longint ub;
      longint r;
      neg_product = (a < 0) != (b < 0);
      ua = (a < 0) ? -a : a;
      ub = (b < 0) ? -b : b;
      r = (ua * ub + (64'sd1 << 23)) >>> 24;
      return neg_product ? -r : r;
   endfunction

   function automatic logic [63:0] int_sqrt(logic [63:0] n);
      logic [63:0] rem;
      logic [63:0] res;
      logic [63:0] bitv;
      rem = n;
      res = 0;
      bitv = 64'd1 << 62;
      for (int i = 0; i < 32; i++) begin
         if (rem >= res + bitv) begin
            rem = rem - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return res;
   endfunction

   // -ln(q * 2^-46) in unsigned Q.24 using the squaring log2 method.
   function automatic logic [63:0] neg_log(logic [63:0] q);
      int unsigned e;
      logic [63:0] y;
      logic [63:0] frac;
      logic [63:0] lq;
      e = 62;
      while (e > 0 && q[e] == 1'b0) e--;
      if (e > TWO_F) e = TWO_F;
      y = (e >= 30) ? (q >> (e - 30)) : (q << (30 - e));
      frac = 0;
      for (int i = 0; i < LOG_ROUNDS; i++) begin
         y = (y * y) >> 30;
         frac = frac << 1;
         if (y >= (64'd1 << 31)) begin
            y = y >> 1;
            frac[0] = 1'b1;
         end
      end
      lq = (64'(TWO_F - e) << LOG_ROUNDS) - frac;
      return (lq * 64'd186065279 + (64'd1 << 31)) >> 32;
   endfunction

   function automatic erfinv_result_type predict_erfinv(logic [ARG_W-1:0] arg);
      erfinv_result_type r;
      logic           neg;
      logic [63:0]    m;
      logic [63:0]    lim;
      logic [63:0]    w;
      logic [63:0]    mag;
      logic [63:0]    pm;
      longint         d;
      longint         p;
      logic           use_high;
      neg = arg[ARG_W-1];
      m = neg ? (64'h1000000 - 64'(arg)) : 64'(arg);
      lim = neg ? 64'h800000 : 64'h7FFFFF;
      r.sat = 1'b0;
      if (m >= (64'd1 << IN_FRAC_BITS)) begin
         mag = lim;
         r.sat = 1'b1;
      end else begin
         w = neg_log((64'd1 << TWO_F) - m * m);
         use_high = (w >= (64'd5 << 24));
         if (!use_high) d = longint'(w) - longint'(64'd5 << 23);
         else d = longint'(int_sqrt(w << 24)) - longint'(64'd3 << 24);
         p = use_high ? HIGH_C[0] : LOW_C[0];
         for (int i = 1; i < 9; i++)
            p = (use_high ? HIGH_C[i] : LOW_C[i]) + scaled_product(p, d);
         pm = (p < 0) ? 64'd0 : ((64'(p) + 2) >> 2);
         mag = (pm * m + (64'd1 << (OUT_SHIFT - 1))) >> OUT_SHIFT;
         if (mag > lim) begin
            mag = lim;
            r.sat = 1'b1;
         end
      end
      r.value = neg ? RES_W'(64'd0 - mag) : RES_W'(mag);
      return r;
   endfunction

   always @(posedge clock) begin
      erfinv_result_type exp_r;
      int                errs;
      errs = 0;
      if (reset) begin
         error_count   <= 0;
         pending_count <= 0;
      end else begin
         if (req_valid && req_ready)
            expected_results.push_back(predict_erfinv(req_arg_value));
         if (rsp_valid && rsp_ready) begin
            if (expected_results.size() == 0) begin
               $error("unexpected result value=%0d", rsp_inv_erf_value);
               errs++;
            end else begin
               exp_r = expected_results.pop_front();
               if (rsp_inv_erf_value !== exp_r.value) begin
                  $error("inv_erf_value expected %0d actual %0d",
                         $signed(exp_r.value), rsp_inv_erf_value);
                  errs++;
               end
               if (rsp_saturated !== exp_r.sat) begin
                  $error("saturated expected %0b actual %0b", exp_r.sat, rsp_saturated);
                  errs++;
               end
            end
         end
         error_count   <= error_count + errs;
         pending_count <= expected_results.size();
      end
   end

endmodule

### sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Inverse error function testbench
// Drives directed and random arguments with random gaps on both channels,
// holds the result side off once to fill the pipeline, and reports the
// checker's verdict.
// ----------------------------------------------------------------------------
module tb_top;
   localparam int ARG_W           = erfinv_pkg::ARG_W;
   localparam int RES_W           = erfinv_pkg::RES_W;
   localparam int RANDOM_REQUESTS = 1930;
   localparam int IDLE_LIMIT      = 20000;
   localparam int DRAIN_CYCLES    = 200;

   logic                    clock;
   logic                    reset;
   logic                    req_valid;
   logic                    req_ready;
   logic signed [ARG_W-1:0] req_arg_value;
   logic                    rsp_valid;
   logic                    rsp_ready;
   logic signed [RES_W-1:0] rsp_inv_erf_value;
   logic                    rsp_saturated;
   int                      error_count;
   int                      pending_count;
   logic                    hold_off;
   int                      idle_cycles;

   inverse_error_function uut (.*);

   erfinv_checker checker_i (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Mostly short gaps, with a long one now and then.
   function automatic int random_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 50) return 0;
      if (roll < 95) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   // Random argument: uniform, near the full-scale ends, near zero, or
   // full scale itself (including the most negative code).
   function automatic logic [ARG_W-1:0] random_argument();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 55) return ARG_W'($urandom());
      if (roll < 80) return ARG_W'(($urandom_range(0, 1) ? 24'h800000 : 24'h7FFFFF)
                                   + ($urandom_range(0, 1) ? 1 : -1)
                                   * $urandom_range(0, 4000));
      if (roll < 95) return ARG_W'($signed($urandom_range(0, 2000)) - 1000);
      return $urandom_range(0, 1) ? 24'h800000 : 24'h7FFFFF;
   endfunction

   // Offers one request and waits until the block accepts it. Valid drops
   // only when a gap follows, so back-to-back requests keep it high.
   task automatic send_request(input logic [ARG_W-1:0] arg);
      int gap;
      gap = random_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_arg_value <= arg;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   // Result side: random stalls, plus one long hold-off while the sender
   // keeps offering requests so the pipeline fills and stops taking them.
   initial begin
      int gap;
      rsp_ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (hold_off) begin
            hold_off = 1'b0;
            gap = 300;
         end else begin
            gap = random_gap();
         end
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         repeat ($urandom_range(1, 20)) @(negedge clock);
      end
   end

   // Watchdog: counts cycles in which no request and no result move.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
         end
      end
   end

   initial begin
      logic [ARG_W-1:0] directed_args [$];
      reset = 1'b1;
      req_valid = 1'b0;
      req_arg_value = '0;
      hold_off = 1'b0;
      idle_cycles = 0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Zero, tiny values, the low/high branch region, near full scale,
      // full scale in both signs and the most negative code.
      directed_args = '{24'h000000, 24'h000001, 24'hFFFFFF, 24'h400000, 24'hC00000,
                        24'h7F0000, 24'h810000, 24'h7FF000, 24'h801000, 24'h7FFF00,
                        24'h800100, 24'h7FFFFE, 24'h800002, 24'h7FFFFF, 24'h800001,
                        24'h800000, 24'h555555, 24'hAAAAAA, 24'h7E8000, 24'h818000};
      foreach (directed_args[i]) send_request(directed_args[i]);

      for (int n = 0; n < RANDOM_REQUESTS; n++) begin
         if (n == RANDOM_REQUESTS / 2) hold_off = 1'b1;
         send_request(random_argument());
      end
      req_valid <= 1'b0;

      while (pending_count != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
